/* rtl/kped_pkg.sv */
package kped_pkg;

  localparam int PIN_W     = 3;
  localparam int KIDX_W    = 2;
  localparam int CNT_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 8;

  typedef enum logic {
    CMD_SCAN = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LONG_PRESS = 1'b0,
    REG_REPEAT     = 1'b1
  } cfg_reg_t;

  localparam logic [CNT_W-1:0] LONG_PRESS_RESET = 8'd50;
  localparam logic [CNT_W-1:0] REPEAT_RESET     = 8'd10;

  typedef struct packed {
    logic                    cmd;
    logic [PIN_W-1:0]        pin_levels;
    logic [KIDX_W-1:0]       key_index;
  } cmd_item_t;

  typedef struct packed {
    logic in_range;
    logic down;
    logic up;
    logic single;
    logic held_long;
    logic repeat_res;
    logic hold;
  } evt_item_t;

  // sticky per-key flags
  typedef struct packed {
    logic hold;
    logic rpt;
    logic held_long;
    logic single;
    logic up;
    logic down;
  } key_flags_t;

  // per-lane control inputs
  typedef struct packed {
    logic tick;
    logic clear;
    logic pressed;
  } lane_ctl_t;

endpackage

/* rtl/kped_lane.sv */
module kped_lane
  import kped_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  lane_ctl_t        ctl,
  input  logic [CNT_W-1:0] long_press_ticks,
  input  logic [CNT_W-1:0] repeat_ticks,
  output key_flags_t       flags
);

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_PRESSED = 2'd1,
    MODE_LONG    = 2'd2
  } mode_t;

  mode_t            mode, mode_next;
  logic [CNT_W-1:0] count, count_next;
  key_flags_t       flags_next;
  logic [CNT_W-1:0] count_inc;

  assign count_inc = count + CNT_W'(1);

  always_comb begin
    mode_next  = mode;
    count_next = count;
    flags_next = flags;
    if (ctl.clear) begin
      flags_next = '0;
      flags_next.hold = flags.hold;
    end else if (ctl.tick) begin
      case (mode)
        MODE_PRESSED: begin
          if (ctl.pressed) begin
            count_next = count_inc;
            if (count_inc >= long_press_ticks) begin
              mode_next = MODE_LONG;
              count_next = '0;
              flags_next.held_long = 1'b1;
            end
          end else begin
            mode_next = MODE_IDLE;
            flags_next.up = 1'b1;
            flags_next.single = 1'b1;
            flags_next.down = 1'b0;
            flags_next.hold = 1'b0;
          end
        end
        MODE_LONG: begin
          if (ctl.pressed) begin
            count_next = count_inc;
            if (count_inc >= repeat_ticks) begin
              count_next = '0;
              flags_next.rpt = 1'b1;
            end
          end else begin
            mode_next = MODE_IDLE;
            flags_next.up = 1'b1;
            flags_next.down = 1'b0;
            flags_next.hold = 1'b0;
            flags_next.rpt = 1'b0;
          end
        end
        default: begin
          if (ctl.pressed) begin
            mode_next = MODE_PRESSED;
            count_next = '0;
            flags_next.down = 1'b1;
            flags_next.hold = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_IDLE;
      count <= '0;
      flags <= '0;
    end else begin
      mode  <= mode_next;
      count <= count_next;
      flags <= flags_next;
    end
  end

endmodule

/* rtl/kped_merge.sv */
module kped_merge
  import kped_pkg::*;
#(
  parameter int KEYS = 3
) (
  input  key_flags_t        key_flags [KEYS],
  input  logic [KIDX_W-1:0] key_index,
  output evt_item_t         evt
);

  key_flags_t sel;
  logic       hit;

  always_comb begin
    sel = '0;
    for (int k = 0; k < KEYS; k++) begin
      if (k == int'(key_index)) sel = key_flags[k];
    end
  end

  assign hit = int'(key_index) < KEYS;

  always_comb begin
    evt = '0;
    if (hit) begin
      evt.in_range   = 1'b1;
      evt.down       = sel.down;
      evt.up         = sel.up;
      evt.single     = sel.single;
      evt.held_long  = sel.held_long;
      evt.repeat_res = sel.rpt;
      evt.hold       = sel.hold;
    end
  end

endmodule

/* rtl/key_press_event_detector.sv */
// key press event detector
//
// cmd channel (cmd_valid / cmd_stall / cmd_data): each transaction is either a
// scan tick carrying the raw active-low pin levels, or a read of one key.
// a scan tick steps every key's idle / pressed / long-pressed machine at once,
// one lane per key, and produces no result. keys beyond the pin field see a
// low level and count as pressed.
// a read returns that key's sticky flags on the evt channel (evt_valid /
// evt_stall / evt_data) in the cycle after acceptance and clears all of them
// but hold; an index at or beyond KEYS returns in_range=0 with all flags zero.
// throughput is one transaction per cycle: the merge stage feeds a single
// output register, and cmd_stall is raised only while that register holds a
// result the receiver is stalling on. a stalled result stays put.
// cfg port: cfg_we writes cfg_data into long_press_ticks (index 0) or
// repeat_ticks (index 1); write only while the block is idle.
// reset (rst, synchronous): all keys idle, counts and flags clear, output
// register empty, limits back to 50 and 10 ticks.
module key_press_event_detector
  import kped_pkg::*;
#(
  parameter int KEYS = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  cmd_item_t            cmd_data,
  output logic                 evt_valid,
  input  logic                 evt_stall,
  output evt_item_t            evt_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CNT_W-1:0] long_press_ticks;
  logic [CNT_W-1:0] repeat_ticks;
  key_flags_t       key_flags [KEYS];
  evt_item_t        merged;
  logic             accept;
  logic             is_read;
  logic             is_scan;

  // output register frees up as soon as the receiver takes it
  assign cmd_stall = evt_valid && evt_stall;
  assign accept    = cmd_valid && !cmd_stall;
  assign is_read   = accept && (cmd_data.cmd == CMD_READ);
  assign is_scan   = accept && (cmd_data.cmd == CMD_SCAN);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= LONG_PRESS_RESET;
      repeat_ticks     <= REPEAT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LONG_PRESS: long_press_ticks <= cfg_data[CNT_W-1:0];
        REG_REPEAT:     repeat_ticks     <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // one lane per key
  for (genvar k = 0; k < KEYS; k++) begin : g_lane
    lane_ctl_t ctl;
    logic      pressed;

    if (k < PIN_W) begin : g_pin
      assign pressed = !cmd_data.pin_levels[k];
    end else begin : g_nopin
      // no pin bit: level reads low, so the key counts as pressed
      assign pressed = 1'b1;
    end

    assign ctl.tick    = is_scan;
    assign ctl.clear   = is_read && (k == int'(cmd_data.key_index));
    assign ctl.pressed = pressed;

    kped_lane u_lane (
      .clk              (clk),
      .rst              (rst),
      .ctl              (ctl),
      .long_press_ticks (long_press_ticks),
      .repeat_ticks     (repeat_ticks),
      .flags            (key_flags[k])
    );
  end

  // pick the addressed key's flags, as they stand before the clear
  kped_merge #(
    .KEYS (KEYS)
  ) u_merge (
    .key_flags (key_flags),
    .key_index (cmd_data.key_index),
    .evt       (merged)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (is_read) begin
      evt_valid <= 1'b1;
    end else if (!evt_stall) begin
      evt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_read) begin
      evt_data <= merged;
    end
  end

`ifndef SYNTH
  a_read_gives_result: assert property (@(posedge clk) disable iff (rst)
    is_read |=> evt_valid)
    else $error("accepted read produced no result");

  a_scan_no_result: assert property (@(posedge clk) disable iff (rst)
    (is_scan && !evt_valid) |=> !evt_valid)
    else $error("scan tick produced a result");

  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    (evt_valid && !evt_data.in_range) |->
      (evt_data.down == 1'b0 && evt_data.up == 1'b0 && evt_data.single == 1'b0 &&
       evt_data.held_long == 1'b0 && evt_data.repeat_res == 1'b0 &&
       evt_data.hold == 1'b0))
    else $error("out of range read carries flags");
`endif

endmodule

/* test/key_press_event_detector_tb.sv */
`timescale 1ns / 100ps

module key_press_event_detector_tb
  import kped_pkg::*;
;

  localparam int NKEYS          = 3;
  localparam int SETTLE_CYCLES  = 4;    // read result shows up in the cycle after acceptance
  localparam int HOLDOFF_CYCLES = 120;  // long receiver stall, fills the output register
  localparam int NPHASES        = 5;

  typedef enum logic [1:0] {
    KM_IDLE    = 2'd0,
    KM_PRESSED = 2'd1,
    KM_LONG    = 2'd2
  } key_mode_e;

  typedef enum logic {
    ROW_XACT = 1'b0,
    ROW_REG  = 1'b1
  } row_kind_e;

  // one row of the directed table: either a transaction or a register write
  typedef struct {
    row_kind_e        kind;
    cmd_item_t        item;
    bit               typed;
    evt_item_t        want;
    cfg_reg_t         sel;
    logic [CFG_W-1:0] value;
  } stim_row_t;

  // dut inputs, known from time zero
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cmd_valid = 1'b0;
  cmd_item_t            cmd_data  = '0;
  logic                 evt_stall = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LONG_PRESS;
  logic [CFG_W-1:0]     cfg_data  = '0;

  logic                 cmd_stall;
  logic                 evt_valid;
  evt_item_t            evt_data;

  // typed-in expectation travels alongside the transaction it belongs to
  bit                   typed_flag = 1'b0;
  evt_item_t            typed_want = '0;

  // key state tracked by the testbench
  key_mode_e            km_mode  [NKEYS];
  logic [CNT_W-1:0]     km_count [NKEYS];
  key_flags_t           km_flags [NKEYS];
  logic [CFG_W-1:0]     long_limit;
  logic [CFG_W-1:0]     repeat_limit;

  evt_item_t            expected_events[$];
  stim_row_t            directed[$];

  // stimulus generator: per-key press/release runs
  logic [PIN_W-1:0]     held_keys;
  int                   run_left [PIN_W];

  bit                   holdoff_req = 1'b0;
  bit                   quiet       = 1'b0;

  int                   mismatch_count = 0;
  int                   n_sent         = 0;
  int                   n_checked      = 0;
  int                   n_out_of_range = 0;
  int                   n_long         = 0;
  int                   n_repeat       = 0;
  int                   n_single       = 0;

  key_press_event_detector #(
    .KEYS(NKEYS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt_data  (evt_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop in case the handshake hangs
  initial begin
    #1_000_000;
    $display("key_press_event_detector_tb: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic got, input logic want);
    mismatch_count++;
    $display("mismatch at %0t: %s got %b expected %b", $time, what, got, want);
  endtask

  // step every key on a scan tick, or queue the flags a read returns
  task automatic track_transaction(input cmd_item_t it, input bit typed, input evt_item_t want);
    evt_item_t ev;
    logic      pressed;
    if (it.cmd == CMD_SCAN) begin
      for (int k = 0; k < NKEYS; k++) begin
        // keys past the pin field read a low level, so they count as pressed
        pressed = (k < PIN_W) ? !it.pin_levels[k] : 1'b1;
        case (km_mode[k])
          KM_PRESSED: begin
            if (pressed) begin
              km_count[k] = km_count[k] + 1'b1;
              if (km_count[k] >= long_limit) begin
                km_mode[k]            = KM_LONG;
                km_count[k]           = '0;
                km_flags[k].held_long = 1'b1;
              end
            end else begin
              km_mode[k]         = KM_IDLE;
              km_flags[k].up     = 1'b1;
              km_flags[k].single = 1'b1;
              km_flags[k].down   = 1'b0;
              km_flags[k].hold   = 1'b0;
            end
          end
          KM_LONG: begin
            if (pressed) begin
              km_count[k] = km_count[k] + 1'b1;
              if (km_count[k] >= repeat_limit) begin
                km_count[k]     = '0;
                km_flags[k].rpt = 1'b1;
              end
            end else begin
              // long press flag survives the release
              km_mode[k]       = KM_IDLE;
              km_flags[k].up   = 1'b1;
              km_flags[k].down = 1'b0;
              km_flags[k].hold = 1'b0;
              km_flags[k].rpt  = 1'b0;
            end
          end
          default: begin
            if (pressed) begin
              km_mode[k]       = KM_PRESSED;
              km_count[k]      = '0;
              km_flags[k].down = 1'b1;
              km_flags[k].hold = 1'b1;
            end
          end
        endcase
      end
    end else begin
      ev = '0;
      if (it.key_index < NKEYS) begin
        ev.in_range   = 1'b1;
        ev.down       = km_flags[it.key_index].down;
        ev.up         = km_flags[it.key_index].up;
        ev.single     = km_flags[it.key_index].single;
        ev.held_long  = km_flags[it.key_index].held_long;
        ev.repeat_res = km_flags[it.key_index].rpt;
        ev.hold       = km_flags[it.key_index].hold;
        // read clears everything but hold
        km_flags[it.key_index]      = '0;
        km_flags[it.key_index].hold = ev.hold;
      end
      expected_events.push_back(typed ? want : ev);
    end
  endtask

  task automatic check_event(input evt_item_t got);
    evt_item_t want;
    if (expected_events.size() == 0) begin
      report_mismatch("result transaction with nothing expected, evt_valid", 1'b1, 1'b0);
    end else begin
      want = expected_events.pop_front();
      n_checked++;
      if (!want.in_range) n_out_of_range++;
      if (want.held_long) n_long++;
      if (want.repeat_res) n_repeat++;
      if (want.single) n_single++;
      if (got.in_range !== want.in_range) report_mismatch("in_range", got.in_range, want.in_range);
      if (got.down !== want.down) report_mismatch("down", got.down, want.down);
      if (got.up !== want.up) report_mismatch("up", got.up, want.up);
      if (got.single !== want.single) report_mismatch("single", got.single, want.single);
      if (got.held_long !== want.held_long)
        report_mismatch("held_long", got.held_long, want.held_long);
      if (got.repeat_res !== want.repeat_res)
        report_mismatch("repeat_res", got.repeat_res, want.repeat_res);
      if (got.hold !== want.hold) report_mismatch("hold", got.hold, want.hold);
    end
  endtask

  // monitor: everything is sampled at the rising edge, before the dut updates
  always @(posedge clk) begin
    if (rst) begin
      long_limit   = LONG_PRESS_RESET;
      repeat_limit = REPEAT_RESET;
      for (int k = 0; k < NKEYS; k++) begin
        km_mode[k]  = KM_IDLE;
        km_count[k] = '0;
        km_flags[k] = '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LONG_PRESS: long_limit   = cfg_data;
          REG_REPEAT:     repeat_limit = cfg_data;
          default: ;
        endcase
      end
      // check before queueing: a read accepted now answers in the next cycle
      if (evt_valid && !evt_stall) check_event(evt_data);
      if (cmd_valid && !cmd_stall) begin
        n_sent++;
        track_transaction(cmd_data, typed_flag, typed_want);
      end
    end
  end

  // receiver: random stall bursts, one long hold-off on request, none when quiet
  initial begin
    int len;
    bit stall_now;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        evt_stall <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end else if (quiet) begin
        evt_stall <= 1'b0;
        @(posedge clk);
      end else begin
        stall_now = ($urandom_range(0, 3) == 0);
        len       = $urandom_range(1, 17);
        evt_stall <= stall_now;
        repeat (len) @(posedge clk);
      end
    end
  end

  // offer one transaction and hold it until accepted
  task automatic send_xact(input cmd_item_t it, input bit typed, input evt_item_t want);
    cmd_data   <= it;
    typed_flag <= typed;
    typed_want <= want;
    cmd_valid  <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    cmd_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // stop sending until every expected result is back, then let scans settle
  task automatic drain(input int settle);
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [CFG_W-1:0] value);
    drain(SETTLE_CYCLES);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic void add_scan(input logic [PIN_W-1:0] pins, input logic [KIDX_W-1:0] idx);
    stim_row_t r;
    r.kind  = ROW_XACT;
    r.item  = '{cmd: CMD_SCAN, pin_levels: pins, key_index: idx};
    r.typed = 1'b0;
    r.want  = '0;
    r.sel   = REG_LONG_PRESS;
    r.value = '0;
    directed.push_back(r);
  endfunction

  function automatic void add_read(input logic [KIDX_W-1:0] idx, input logic [PIN_W-1:0] pins,
                                   input bit typed, input evt_item_t want);
    stim_row_t r;
    r.kind  = ROW_XACT;
    r.item  = '{cmd: CMD_READ, pin_levels: pins, key_index: idx};
    r.typed = typed;
    r.want  = want;
    r.sel   = REG_LONG_PRESS;
    r.value = '0;
    directed.push_back(r);
  endfunction

  function automatic void add_reg(input cfg_reg_t sel, input logic [CFG_W-1:0] value);
    stim_row_t r;
    r.kind  = ROW_REG;
    r.item  = '0;
    r.typed = 1'b0;
    r.want  = '0;
    r.sel   = sel;
    r.value = value;
    directed.push_back(r);
  endfunction

  // mostly held/released runs per key so presses reach long press and repeat;
  // one scan in ten is random pin noise
  task automatic build_random(input int read_pct, input int lp, input int rp,
                              output cmd_item_t it);
    it.key_index  = KIDX_W'($urandom_range(0, 3));
    it.pin_levels = PIN_W'($urandom_range(0, 7));
    if ($urandom_range(1, 100) <= read_pct) begin
      it.cmd = CMD_READ;
    end else begin
      it.cmd = CMD_SCAN;
      if ($urandom_range(0, 9) != 0) begin
        for (int k = 0; k < PIN_W; k++) begin
          if (run_left[k] == 0) begin
            held_keys[k] = ~held_keys[k];
            if (!held_keys[k])
              run_left[k] = $urandom_range(1, 6);
            else if ($urandom_range(0, 1) != 0)
              run_left[k] = $urandom_range(1, lp + 1);       // short press
            else
              run_left[k] = lp + 1 + $urandom_range(1, 3 * rp + 4);  // long press
          end
          run_left[k]--;
          it.pin_levels[k] = ~held_keys[k];
        end
      end
    end
  endtask

  // stimulus
  initial begin
    int        ph_lp    [NPHASES];
    int        ph_rp    [NPHASES];
    int        ph_items [NPHASES];
    int        ph_read  [NPHASES];
    cmd_item_t it;

    ph_lp    = '{3, 255, 1, 50, 0};
    ph_rp    = '{2, 255, 1, 10, 0};
    ph_items = '{300, 450, 250, 400, 400};
    ph_read  = '{25, 10, 30, 20, 25};
    ph_lp[4] = $urandom_range(2, 20);
    ph_rp[4] = $urandom_range(1, 8);

    held_keys = '0;
    for (int k = 0; k < PIN_W; k++) run_left[k] = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: reset state, out-of-range reads, press and release, then
    // limits of one and zero for long press and repeat, then the largest limits
    add_read(2'd0, 3'b111, 1'b1, 7'b1000000);
    add_read(2'd3, 3'b000, 1'b1, 7'b0000000);
    add_scan(3'b000, 2'd3);
    add_read(2'd0, 3'b010, 1'b1, 7'b1100001);
    add_read(2'd0, 3'b101, 1'b1, 7'b1000001);
    add_scan(3'b111, 2'd0);
    add_read(2'd1, 3'b000, 1'b1, 7'b1011000);
    add_read(2'd3, 3'b101, 1'b1, 7'b0000000);  // must not clear key flags
    add_reg(REG_LONG_PRESS, 8'd1);
    add_reg(REG_REPEAT, 8'd1);
    add_scan(3'b110, 2'd1);
    add_scan(3'b110, 2'd2);
    add_scan(3'b110, 2'd3);
    add_read(2'd0, 3'b111, 1'b0, '0);
    add_scan(3'b111, 2'd0);
    add_read(2'd0, 3'b000, 1'b0, '0);
    add_read(2'd2, 3'b111, 1'b0, '0);
    add_reg(REG_LONG_PRESS, 8'd0);
    add_reg(REG_REPEAT, 8'd0);
    add_scan(3'b000, 2'd0);
    add_scan(3'b000, 2'd1);
    add_scan(3'b000, 2'd2);
    add_read(2'd1, 3'b011, 1'b0, '0);
    add_read(2'd2, 3'b100, 1'b0, '0);
    add_scan(3'b111, 2'd3);
    add_read(2'd0, 3'b001, 1'b0, '0);
    add_reg(REG_LONG_PRESS, 8'd255);
    add_reg(REG_REPEAT, 8'd255);
    add_scan(3'b010, 2'd1);
    add_read(2'd2, 3'b110, 1'b0, '0);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_REG)
        write_reg(directed[i].sel, directed[i].value);
      else
        send_xact(directed[i].item, directed[i].typed, directed[i].want);
    end

    // random phases, one register setting each
    for (int ph = 0; ph < NPHASES; ph++) begin
      write_reg(REG_LONG_PRESS, CFG_W'(ph_lp[ph]));
      write_reg(REG_REPEAT, CFG_W'(ph_rp[ph]));
      for (int n = 0; n < ph_items[ph]; n++) begin
        if (ph == 0 && n == 60) holdoff_req = 1'b1;    // sender keeps going meanwhile
        if (ph == 3 && n == 200) drain(0);             // sender waits for all results
        if (ph == NPHASES - 1 && n == ph_items[ph] / 2) quiet = 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) pause_sender($urandom_range(1, 17));
        build_random(ph_read[ph], ph_lp[ph], ph_rp[ph], it);
        send_xact(it, 1'b0, '0);
      end
    end

    drain(2 * SETTLE_CYCLES);

    $display("ran %0d transactions over %0d register settings, limits 0, 1 and 255 included",
             n_sent, NPHASES + 3);
    $display("checked %0d results: %0d out of range, %0d single, %0d long press, %0d repeat",
             n_checked, n_out_of_range, n_single, n_long, n_repeat);
    if (mismatch_count == 0) begin
      $display("key_press_event_detector_tb: PASS");
    end else begin
      $display("key_press_event_detector_tb: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/kped_pkg.sv
rtl/kped_lane.sv
rtl/kped_merge.sv
rtl/key_press_event_detector.sv
test/key_press_event_detector_tb.sv
